>>> rtl/core/angle_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// angle packet deframer assertion macros
// shared property forms for the deframer and its output queue
// ----------------------------------------------------------------------------
`ifndef ANGLE_PACKET_DEFRAMER_DEFINES_SVH
`define ANGLE_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define APD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/apd_pkg.sv
// ----------------------------------------------------------------------------
// apd_pkg
// constants and types shared by the angle packet deframer modules
// ----------------------------------------------------------------------------
package apd_pkg;

	// capture store size in bytes, kept as two byte banks of half the depth
	localparam int STORE_BYTES = 4096;
	localparam int WORD_DEPTH  = STORE_BYTES / 2;
	localparam int WORD_AW     = $clog2(WORD_DEPTH);
	localparam int IDXW        = $clog2(STORE_BYTES) + 1;

	// output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int LVLW       = $clog2(FIFO_DEPTH + 1);

	// framing bytes and packet types
	localparam logic [7:0] SYNC1    = 8'hAA;
	localparam logic [7:0] SYNC2    = 8'hBB;
	localparam logic [7:0] TAIL1    = 8'hCC;
	localparam logic [7:0] TAIL2    = 8'hDD;
	localparam logic [7:0] KIND_2D  = 8'h02;
	localparam logic [7:0] KIND_3D  = 8'h03;
	localparam logic [7:0] KIND_RAW = 8'h04;

	// result kinds
	localparam logic [1:0] RES_2D   = 2'd0;
	localparam logic [1:0] RES_3D   = 2'd1;
	localparam logic [1:0] RES_RAW  = 2'd2;
	localparam logic [1:0] RES_READ = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] azimuth;
		logic [15:0] elevation;
		logic [7:0]  strength;
		logic [7:0]  channels;
		logic [15:0] samples;
		logic [15:0] value;
		logic        err;
	} res_t;

endpackage

>>> rtl/core/angle_packet_deframer.sv
// ----------------------------------------------------------------------------
// angle_packet_deframer
// deframes angle and raw capture packets from a received byte stream
// ----------------------------------------------------------------------------
// The slave channel carries one item per byte received (s_tuser = 0) or a
// request to read back one captured sample (s_tuser = 1). Packets are
// AA BB, type, body, CC DD; type 2 and 3 give an angle result, type 4 fills
// the capture store with big-endian samples and gives a completion result.
// Bad framing bytes drop silently back to hunting for AA.
// Every item goes through a three-stage pipe: parse and multiply, store
// address and read, result assembly into a four-entry result queue. A result
// passes the stage one and stage two registers and is written into the queue
// before it shows on the master channel.
// One item per cycle is taken while the queue plus the pipe hold fewer than
// four results; the capture store is two byte-wide rams (even and odd bytes)
// so a sample read uses one read of both rams and a byte write one write.
// When the master side stalls, results wait in the queue and s_tready falls
// once four results are queued or in flight; nothing is dropped.
// Reset returns the parser to hunting and clears counts, so every read gives
// an index error until a type 4 header arrives. The store is not cleared;
// reading never-written bytes gives undefined sample values.
// ----------------------------------------------------------------------------
`include "angle_packet_deframer_defines.svh"

module angle_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // rx_byte[7:0], read_channel[15:8], read_sample[31:16]
	input  logic [0:0]  s_tuser,   // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // azimuth_tenths[15:0], elevation_tenths[31:16],
	                               // strength[39:32], channel_count[47:40],
	                               // sample_count[63:48], sample_value[79:64]
	output logic [2:0]  m_tuser    // result_kind[1:0], read_error[2]
);

	localparam int IDXW = apd_pkg::IDXW;
	localparam int WAW  = apd_pkg::WORD_AW;
	localparam int LW   = apd_pkg::LVLW;

	// parser states
	localparam logic [3:0] ST_HUNT  = 4'd0;
	localparam logic [3:0] ST_SYNC2 = 4'd1;
	localparam logic [3:0] ST_TYPE  = 4'd2;
	localparam logic [3:0] ST_AZH   = 4'd3;
	localparam logic [3:0] ST_AZL   = 4'd4;
	localparam logic [3:0] ST_ELH   = 4'd5;
	localparam logic [3:0] ST_ELL   = 4'd6;
	localparam logic [3:0] ST_STR   = 4'd7;
	localparam logic [3:0] ST_NCH   = 4'd8;
	localparam logic [3:0] ST_NH    = 4'd9;
	localparam logic [3:0] ST_NL    = 4'd10;
	localparam logic [3:0] ST_BODY  = 4'd11;
	localparam logic [3:0] ST_TAIL1 = 4'd12;
	localparam logic [3:0] ST_TAIL2 = 4'd13;

	// input fields
	logic        req_type;
	logic [7:0]  rx_byte;
	logic [7:0]  read_channel;
	logic [15:0] read_sample;

	assign req_type     = s_tuser[0];
	assign rx_byte      = s_tdata[7:0];
	assign read_channel = s_tdata[15:8];
	assign read_sample  = s_tdata[31:16];

	logic s_acc, byte_take, rd_take;
	assign s_acc     = s_tvalid && s_tready;
	assign byte_take = s_acc && !req_type;
	assign rd_take   = s_acc && req_type;

	// parser registers
	logic [3:0]      state_q, state_d;
	logic            kind3_q, kind3_d;
	logic            kindraw_q, kindraw_d;
	logic [15:0]     az_q, az_d;
	logic [15:0]     el_q, el_d;
	logic [7:0]      str_q, str_d;
	logic [7:0]      chans_q, chans_d;
	logic [15:0]     samps_q, samps_d;
	logic [IDXW-1:0] total_q, total_d;
	logic [IDXW-1:0] widx_q, widx_d;

	// header arithmetic and store write
	logic [23:0]     hdr_prod;
	logic [24:0]     hdr_total;
	logic [IDXW-1:0] widx_inc;
	logic            mem_we;
	logic            hit;
	apd_pkg::res_t   res_b;

	assign hdr_prod  = chans_q * {samps_q[15:8], rx_byte};
	assign hdr_total = {hdr_prod, 1'b0};
	assign widx_inc  = widx_q + 1'b1;

	// byte parser
	always_comb begin
		state_d   = state_q;
		kind3_d   = kind3_q;
		kindraw_d = kindraw_q;
		az_d      = az_q;
		el_d      = el_q;
		str_d     = str_q;
		chans_d   = chans_q;
		samps_d   = samps_q;
		total_d   = total_q;
		widx_d    = widx_q;
		mem_we    = 1'b0;
		hit       = 1'b0;
		res_b     = '0;
		if (byte_take) begin
			unique case (state_q)
				ST_HUNT: begin
					if (rx_byte == apd_pkg::SYNC1) begin
						state_d = ST_SYNC2;
					end
				end
				ST_SYNC2: begin
					state_d = (rx_byte == apd_pkg::SYNC2) ? ST_TYPE : ST_HUNT;
				end
				ST_TYPE: begin
					kind3_d   = (rx_byte == apd_pkg::KIND_3D);
					kindraw_d = (rx_byte == apd_pkg::KIND_RAW);
					if (rx_byte == apd_pkg::KIND_2D || rx_byte == apd_pkg::KIND_3D) begin
						state_d = ST_AZH;
					end else if (rx_byte == apd_pkg::KIND_RAW) begin
						state_d = ST_NCH;
					end else begin
						state_d = ST_HUNT;
					end
				end
				ST_AZH: begin
					az_d    = {rx_byte, 8'h00};
					state_d = ST_AZL;
				end
				ST_AZL: begin
					az_d    = {az_q[15:8], rx_byte};
					state_d = kind3_q ? ST_ELH : ST_STR;
				end
				ST_ELH: begin
					el_d    = {rx_byte, 8'h00};
					state_d = ST_ELL;
				end
				ST_ELL: begin
					el_d    = {el_q[15:8], rx_byte};
					state_d = ST_STR;
				end
				ST_STR: begin
					str_d   = rx_byte;
					state_d = ST_TAIL1;
				end
				ST_NCH: begin
					chans_d = rx_byte;
					state_d = ST_NH;
				end
				ST_NH: begin
					samps_d = {rx_byte, 8'h00};
					state_d = ST_NL;
				end
				ST_NL: begin
					samps_d = {samps_q[15:8], rx_byte};
					total_d = hdr_total[IDXW-1:0];
					widx_d  = '0;
					if (chans_q == '0 || samps_d == '0 ||
					    hdr_total > 25'(apd_pkg::STORE_BYTES)) begin
						state_d = ST_HUNT;
					end else begin
						state_d = ST_BODY;
					end
				end
				ST_BODY: begin
					mem_we = 1'b1;
					widx_d = widx_inc;
					if (widx_inc >= total_q) begin
						state_d = ST_TAIL1;
					end
				end
				ST_TAIL1: begin
					state_d = (rx_byte == apd_pkg::TAIL1) ? ST_TAIL2 : ST_HUNT;
				end
				ST_TAIL2: begin
					state_d = ST_HUNT;
					if (rx_byte == apd_pkg::TAIL2) begin
						hit = 1'b1;
						if (kindraw_q) begin
							res_b.kind     = apd_pkg::RES_RAW;
							res_b.channels = chans_q;
							res_b.samples  = samps_q;
						end else begin
							res_b.kind      = kind3_q ? apd_pkg::RES_3D : apd_pkg::RES_2D;
							res_b.azimuth   = az_q;
							res_b.elevation = kind3_q ? el_q : 16'h0000;
							res_b.strength  = str_q;
						end
					end
				end
				default: begin
					state_d = ST_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			kind3_q   <= 1'b0;
			kindraw_q <= 1'b0;
			az_q      <= '0;
			el_q      <= '0;
			str_q     <= '0;
			chans_q   <= '0;
			samps_q   <= '0;
			total_q   <= '0;
			widx_q    <= '0;
		end else begin
			state_q   <= state_d;
			kind3_q   <= kind3_d;
			kindraw_q <= kindraw_d;
			az_q      <= az_d;
			el_q      <= el_d;
			str_q     <= str_d;
			chans_q   <= chans_d;
			samps_q   <= samps_d;
			total_q   <= total_d;
			widx_q    <= widx_d;
		end
	end

	// stage 1: read bounds and channel offset product
	logic          v_s1, rd_s1, inb_s1;
	logic [23:0]   prod_s1;
	logic [15:0]   samp_s1;
	apd_pkg::res_t res_s1;
	logic          inb_now;
	apd_pkg::res_t res_rd;

	assign inb_now = (read_channel < chans_q) && (read_sample < samps_q);

	always_comb begin
		res_rd      = '0;
		res_rd.kind = apd_pkg::RES_READ;
		res_rd.err  = !inb_now;
	end

	// stage 2: word address into the store
	logic          v_s2, rd_s2, ok_s2;
	apd_pkg::res_t res_s2;
	logic [24:0]   word_idx;
	logic          in_store;
	logic [WAW-1:0] raddr;

	assign word_idx = 25'(prod_s1) + 25'(samp_s1);
	assign in_store = word_idx < 25'(apd_pkg::WORD_DEPTH);
	assign raddr    = word_idx[WAW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			rd_s1 <= 1'b0;
			v_s2  <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			v_s1  <= hit || rd_take;
			rd_s1 <= rd_take;
			v_s2  <= v_s1;
			rd_s2 <= rd_s1;
		end
	end

	// pipe payload
	always_ff @(posedge clk) begin
		prod_s1 <= read_channel * samps_q;
		samp_s1 <= read_sample;
		inb_s1  <= inb_now;
		res_s1  <= rd_take ? res_rd : res_b;
		ok_s2   <= inb_s1 && in_store;
		res_s2  <= res_s1;
	end

	// capture store: even and odd byte banks
	logic [7:0]     even_rd, odd_rd;
	logic [WAW-1:0] waddr;

	assign waddr = widx_q[WAW:1];

	apd_ram #(
		.WIDTH (8),
		.DEPTH (apd_pkg::WORD_DEPTH)
	) u_even (
		.clk   (clk),
		.we    (mem_we && !widx_q[0]),
		.waddr (waddr),
		.wdata (rx_byte),
		.raddr (raddr),
		.rdata (even_rd)
	);

	apd_ram #(
		.WIDTH (8),
		.DEPTH (apd_pkg::WORD_DEPTH)
	) u_odd (
		.clk   (clk),
		.we    (mem_we && widx_q[0]),
		.waddr (waddr),
		.wdata (rx_byte),
		.raddr (raddr),
		.rdata (odd_rd)
	);

	// stage 3: sample assembly into the result queue
	apd_pkg::res_t push_res;
	apd_pkg::res_t out_res;
	logic [LW-1:0] fifo_level;
	logic [LW-1:0] inflight;

	always_comb begin
		push_res = res_s2;
		if (rd_s2 && ok_s2) begin
			push_res.value = {even_rd, odd_rd};
		end
	end

	apd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (push_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res),
		.level     (fifo_level)
	);

	// credit: queued results plus those still in the pipe
	assign inflight = fifo_level + LW'(v_s1) + LW'(v_s2);
	assign s_tready = inflight < LW'(apd_pkg::FIFO_DEPTH);

	// output packing
	assign m_tdata = {out_res.value, out_res.samples, out_res.channels,
	                  out_res.strength, out_res.elevation, out_res.azimuth};
	assign m_tuser = {out_res.err, out_res.kind};

	`APD_ASSERT_IMPL(a_body_bound, clk, arst_n, state_q == ST_BODY, widx_q < total_q && total_q <= IDXW'(apd_pkg::STORE_BYTES), "capture index beyond header total")
	`APD_ASSERT_IMPL(a_credit, clk, arst_n, 1'b1, inflight <= LW'(apd_pkg::FIFO_DEPTH), "more results in flight than queue space")
	`APD_ASSERT_NEXT(a_read_flow, clk, arst_n, rd_take, v_s1 && rd_s1, "read item lost in stage one")

endmodule

>>> rtl/core/apd_ram.sv
// ----------------------------------------------------------------------------
// apd_ram
// simple dual-port ram, one write and one registered read, old data on clash
// ----------------------------------------------------------------------------
module apd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/apd_out_fifo.sv
// ----------------------------------------------------------------------------
// apd_out_fifo
// small result queue in front of the output channel, reports its fill level
// ----------------------------------------------------------------------------
`include "angle_packet_deframer_defines.svh"

module apd_out_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  apd_pkg::res_t             push_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output apd_pkg::res_t             out_data,
	output logic [apd_pkg::LVLW-1:0]  level
);

	localparam int DEPTH = apd_pkg::FIFO_DEPTH;
	localparam int AW    = apd_pkg::FIFO_AW;
	localparam int LW    = apd_pkg::LVLW;

	apd_pkg::res_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [LW-1:0]   level_q;
	logic            pop;

	assign out_valid = (level_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign level     = level_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	`APD_ASSERT_IMPL(a_no_overflow, clk, arst_n, push && !pop, level_q < LW'(DEPTH), "result queue overflow")
	`APD_ASSERT_NEXT(a_level_up, clk, arst_n, push && !pop, level_q == $past(level_q) + 1'b1, "queue level did not rise")
	`APD_ASSERT_NEXT(a_level_hold, clk, arst_n, !push && !pop, $stable(level_q), "queue level moved while idle")

endmodule
